/* rtl/core/gcsp_pkg.sv */
// Shared types and constants of the grid cell stepper positioner.
package gcsp_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_HOME = 2'd1;
	localparam logic [1:0] OP_GOTO = 2'd2;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_OOB     = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	localparam logic [2:0] REG_MOVE_PERIOD = 3'd0;
	localparam logic [2:0] REG_HOME_PERIOD = 3'd1;
	localparam logic [2:0] REG_X_SPC       = 3'd2;
	localparam logic [2:0] REG_Y_SPC       = 3'd3;
	localparam logic [2:0] REG_GRID_COLS   = 3'd4;
	localparam logic [2:0] REG_GRID_ROWS   = 3'd5;
	localparam logic [2:0] REG_X_LIMIT     = 3'd6;
	localparam logic [2:0] REG_Y_LIMIT     = 3'd7;

	localparam logic [15:0] RST_MOVE_PERIOD = 16'd2000;
	localparam logic [15:0] RST_HOME_PERIOD = 16'd3000;
	localparam logic [11:0] RST_X_SPC       = 12'd200;
	localparam logic [11:0] RST_Y_SPC       = 12'd200;
	localparam logic [4:0]  RST_GRID_COLS   = 5'd4;
	localparam logic [4:0]  RST_GRID_ROWS   = 5'd3;
	localparam logic [15:0] RST_X_LIMIT     = 16'd1600;
	localparam logic [15:0] RST_Y_LIMIT     = 16'd1200;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_HOME_X = 5'b00010,
		PH_HOME_Y = 5'b00100,
		PH_MOVE_X = 5'b01000,
		PH_MOVE_Y = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] target_col;
		logic [3:0] target_row;
		logic       x_home_level;
		logic       y_home_level;
	} cmd_t;

	typedef struct packed {
		logic       x_step;
		logic       y_step;
		logic       step_forward;
		logic       busy_res;
		logic [2:0] status;
		logic [3:0] position_col;
		logic [3:0] position_row;
		logic       is_homed;
	} res_t;

	typedef struct packed {
		logic [2:0]  reg_index;
		logic [15:0] wdata;
	} cfg_t;

endpackage

/* rtl/core/gcsp_if.sv */
// Handshake channels of the grid cell stepper positioner.
interface gcsp_cmd_if ();
	logic              valid;
	logic              ready;
	gcsp_pkg::cmd_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gcsp_res_if ();
	logic              valid;
	logic              ready;
	gcsp_pkg::res_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gcsp_cfg_if ();
	logic              valid;
	logic              ready;
	gcsp_pkg::cfg_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/grid_cell_stepper_positioner_unit.sv */
// Top level of the two-axis grid cell stepper positioner.
// Result: the result of a tick is registered and presented in the cycle after its command transfer.
// Throughput: one tick per cycle; the single result register stalls intake only
// while its result waits and the result channel is not ready.
// Reset: asynchronous, active low; idle, position (0,0), not homed, registers at defaults.
// The configuration channel is always ready; a write lands in the next cycle.
module grid_cell_stepper_positioner_unit #(
	parameter int MAX_COLUMNS = 16,
	parameter int MAX_ROWS    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gcsp_cmd_if.sink   cmd,
	gcsp_res_if.source res,
	gcsp_cfg_if.sink   cfg
);

	localparam logic [8:0] MAX_COLS_W = 9'(MAX_COLUMNS);
	localparam logic [8:0] MAX_ROWS_W = 9'(MAX_ROWS);

	logic [15:0] move_period_q, home_period_q, x_limit_q, y_limit_q;
	logic [11:0] x_spc_q, y_spc_q;
	logic [4:0]  grid_cols_q, grid_rows_q;

	gcsp_pkg::phase_t phase_q, phase_n;
	logic [15:0] cnt_q, cnt_n, timer_q, timer_n, pend_q, pend_n;
	logic [1:0]  mdir_q, mdir_n;
	logic [3:0]  col_q, col_n, row_q, row_n;
	logic [7:0]  latch_q, latch_n;
	logic        homed_q, homed_n;

	logic        xs, ys, dir;
	logic [2:0]  st;
	logic        hy, my;
	logic [15:0] hcnt, mcnt, home_reload, move_reload;
	logic [8:0]  cols_lim, rows_lim;
	logic [3:0]  dx, dy;
	logic        accept;
	gcsp_pkg::res_t res_q;
	logic        res_valid_q;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	assign home_reload = (home_period_q == 16'd0) ? 16'd0 : home_period_q - 16'd1;
	assign move_reload = (move_period_q == 16'd0) ? 16'd0 : move_period_q - 16'd1;
	assign cols_lim = ({4'd0, grid_cols_q} < MAX_COLS_W) ? {4'd0, grid_cols_q} : MAX_COLS_W;
	assign rows_lim = ({4'd0, grid_rows_q} < MAX_ROWS_W) ? {4'd0, grid_rows_q} : MAX_ROWS_W;
	assign dx = (cmd.payload.target_col >= col_q) ? cmd.payload.target_col - col_q
		: col_q - cmd.payload.target_col;
	assign dy = (cmd.payload.target_row >= row_q) ? cmd.payload.target_row - row_q
		: row_q - cmd.payload.target_row;

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		timer_n = timer_q;
		pend_n  = pend_q;
		mdir_n  = mdir_q;
		col_n   = col_q;
		row_n   = row_q;
		latch_n = latch_q;
		homed_n = homed_q;
		xs      = 1'b0;
		ys      = 1'b0;
		dir     = 1'b0;
		st      = gcsp_pkg::ST_NONE;
		hy      = 1'b0;
		my      = 1'b0;
		hcnt    = cnt_q;
		mcnt    = cnt_q;
		if (phase_q != gcsp_pkg::PH_IDLE) begin
			if (timer_q != 16'd0) begin
				timer_n = timer_q - 16'd1;
			end else begin
				case (phase_q)
					gcsp_pkg::PH_HOME_X: begin
						if (cnt_q >= x_limit_q) begin
							phase_n = gcsp_pkg::PH_IDLE;
							st      = gcsp_pkg::ST_MISSING;
						end else if (!cmd.payload.x_home_level) begin
							hy   = 1'b1;
							hcnt = 16'd0;
						end else begin
							xs      = 1'b1;
							cnt_n   = cnt_q + 16'd1;
							timer_n = home_reload;
						end
					end
					gcsp_pkg::PH_HOME_Y: hy = 1'b1;
					gcsp_pkg::PH_MOVE_X: begin
						if (cnt_q == 16'd0) begin
							my   = 1'b1;
							mcnt = pend_q;
						end else begin
							xs      = 1'b1;
							dir     = mdir_q[0];
							cnt_n   = cnt_q - 16'd1;
							timer_n = move_reload;
						end
					end
					gcsp_pkg::PH_MOVE_Y: my = 1'b1;
					default: phase_n = gcsp_pkg::PH_IDLE;
				endcase
				if (hy) begin
					if (hcnt >= y_limit_q) begin
						phase_n = gcsp_pkg::PH_IDLE;
						st      = gcsp_pkg::ST_MISSING;
						cnt_n   = hcnt;
					end else if (!cmd.payload.y_home_level) begin
						phase_n = gcsp_pkg::PH_IDLE;
						st      = gcsp_pkg::ST_OK;
						cnt_n   = hcnt;
						col_n   = 4'd0;
						row_n   = 4'd0;
						homed_n = 1'b1;
					end else begin
						phase_n = gcsp_pkg::PH_HOME_Y;
						ys      = 1'b1;
						cnt_n   = hcnt + 16'd1;
						timer_n = home_reload;
					end
				end
				if (my) begin
					if (mcnt == 16'd0) begin
						phase_n = gcsp_pkg::PH_IDLE;
						st      = gcsp_pkg::ST_OK;
						cnt_n   = mcnt;
						col_n   = latch_q[3:0];
						row_n   = latch_q[7:4];
					end else begin
						phase_n = gcsp_pkg::PH_MOVE_Y;
						ys      = 1'b1;
						dir     = mdir_q[1];
						cnt_n   = mcnt - 16'd1;
						timer_n = move_reload;
					end
				end
			end
			if (st == gcsp_pkg::ST_NONE && (cmd.payload.operation == gcsp_pkg::OP_HOME
				|| cmd.payload.operation == gcsp_pkg::OP_GOTO)) begin
				st = gcsp_pkg::ST_BUSY;
			end
		end else if (cmd.payload.operation == gcsp_pkg::OP_HOME) begin
			phase_n = gcsp_pkg::PH_HOME_X;
			cnt_n   = 16'd0;
			timer_n = 16'd0;
		end else if (cmd.payload.operation == gcsp_pkg::OP_GOTO) begin
			if ({5'd0, cmd.payload.target_col} >= cols_lim
				|| {5'd0, cmd.payload.target_row} >= rows_lim) begin
				st = gcsp_pkg::ST_OOB;
			end else begin
				mdir_n  = {cmd.payload.target_row >= row_q, cmd.payload.target_col >= col_q};
				cnt_n   = {12'd0, dx} * {4'd0, x_spc_q};
				pend_n  = {12'd0, dy} * {4'd0, y_spc_q};
				latch_n = {cmd.payload.target_row, cmd.payload.target_col};
				timer_n = 16'd0;
				phase_n = gcsp_pkg::PH_MOVE_X;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_period_q <= gcsp_pkg::RST_MOVE_PERIOD;
			home_period_q <= gcsp_pkg::RST_HOME_PERIOD;
			x_spc_q       <= gcsp_pkg::RST_X_SPC;
			y_spc_q       <= gcsp_pkg::RST_Y_SPC;
			grid_cols_q   <= gcsp_pkg::RST_GRID_COLS;
			grid_rows_q   <= gcsp_pkg::RST_GRID_ROWS;
			x_limit_q     <= gcsp_pkg::RST_X_LIMIT;
			y_limit_q     <= gcsp_pkg::RST_Y_LIMIT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.payload.reg_index)
				gcsp_pkg::REG_MOVE_PERIOD: move_period_q <= cfg.payload.wdata;
				gcsp_pkg::REG_HOME_PERIOD: home_period_q <= cfg.payload.wdata;
				gcsp_pkg::REG_X_SPC:       x_spc_q       <= cfg.payload.wdata[11:0];
				gcsp_pkg::REG_Y_SPC:       y_spc_q       <= cfg.payload.wdata[11:0];
				gcsp_pkg::REG_GRID_COLS:   grid_cols_q   <= cfg.payload.wdata[4:0];
				gcsp_pkg::REG_GRID_ROWS:   grid_rows_q   <= cfg.payload.wdata[4:0];
				gcsp_pkg::REG_X_LIMIT:     x_limit_q     <= cfg.payload.wdata;
				gcsp_pkg::REG_Y_LIMIT:     y_limit_q     <= cfg.payload.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gcsp_pkg::PH_IDLE;
			cnt_q   <= 16'd0;
			timer_q <= 16'd0;
			pend_q  <= 16'd0;
			mdir_q  <= 2'd0;
			col_q   <= 4'd0;
			row_q   <= 4'd0;
			latch_q <= 8'd0;
			homed_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			timer_q <= timer_n;
			pend_q  <= pend_n;
			mdir_q  <= mdir_n;
			col_q   <= col_n;
			row_q   <= row_n;
			latch_q <= latch_n;
			homed_q <= homed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.x_step       <= xs;
			res_q.y_step       <= ys;
			res_q.step_forward <= dir;
			res_q.busy_res     <= (phase_n != gcsp_pkg::PH_IDLE);
			res_q.status       <= st;
			res_q.position_col <= col_n;
			res_q.position_row <= row_n;
			res_q.is_homed     <= homed_n;
		end
	end

	a_new_result_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(accept))
		else $error("result appeared without a command transfer");

	a_single_axis_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.x_step && res_q.y_step))
		else $error("both axes pulsed in one tick");

	a_final_status_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status == gcsp_pkg::ST_OK || res_q.status == gcsp_pkg::ST_OOB
		|| res_q.status == gcsp_pkg::ST_MISSING) |-> !res_q.busy_res)
		else $error("finished sequence still reported busy");

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == gcsp_pkg::PH_IDLE |-> timer_q == 16'd0)
		else $error("period timer running while idle");

	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(homed_q))
		else $error("homed flag cleared");

endmodule

/* tb/gcsp_result_check.sv */
// Predicts and checks every result of the grid cell stepper positioner.
module gcsp_result_check #(
	parameter int MAX_COLUMNS = 16,
	parameter int MAX_ROWS    = 16
) (
	input  logic clk,
	input  logic arst_n,
	gcsp_cmd_if  cmd,
	gcsp_res_if  res,
	gcsp_cfg_if  cfg,
	output int   fails,
	output int   waiting,
	output logic seq_busy
);
	timeunit 1ns;
	timeprecision 1ps;
	import gcsp_pkg::*;

	logic [15:0] move_per, home_per, x_lim, y_lim;
	logic [11:0] x_spc, y_spc;
	logic [4:0]  cols, rows;

	phase_t      phase;
	logic [15:0] step_cnt, tick_timer, y_backlog;
	logic [1:0]  fwd;
	logic [3:0]  cur_col, cur_row, dest_col, dest_row;
	logic        homed;

	res_t due_outputs[$];
	int   err_count = 0;

	assign fails = err_count;

	function automatic logic [15:0] reload(logic [15:0] p);
		return (p == 16'd0) ? 16'd0 : p - 16'd1;
	endfunction

	function automatic logic [2:0] advance_axes(input cmd_t c, inout res_t r);
		if (tick_timer != 16'd0) begin
			tick_timer = tick_timer - 16'd1;
			return ST_NONE;
		end
		if (phase == PH_HOME_X) begin
			if (step_cnt >= x_lim) begin
				phase = PH_IDLE;
				return ST_MISSING;
			end
			if (!c.x_home_level) begin
				phase = PH_HOME_Y;
				step_cnt = 16'd0;
			end else begin
				r.x_step = 1'b1;
				r.step_forward = 1'b0;
				step_cnt = step_cnt + 16'd1;
				tick_timer = reload(home_per);
				return ST_NONE;
			end
		end
		if (phase == PH_HOME_Y) begin
			if (step_cnt >= y_lim) begin
				phase = PH_IDLE;
				return ST_MISSING;
			end
			if (!c.y_home_level) begin
				phase = PH_IDLE;
				cur_col = 4'd0;
				cur_row = 4'd0;
				homed = 1'b1;
				return ST_OK;
			end
			r.y_step = 1'b1;
			r.step_forward = 1'b0;
			step_cnt = step_cnt + 16'd1;
			tick_timer = reload(home_per);
			return ST_NONE;
		end
		if (phase == PH_MOVE_X) begin
			if (step_cnt == 16'd0) begin
				phase = PH_MOVE_Y;
				step_cnt = y_backlog;
			end else begin
				r.x_step = 1'b1;
				r.step_forward = fwd[0];
				step_cnt = step_cnt - 16'd1;
				tick_timer = reload(move_per);
				return ST_NONE;
			end
		end
		if (phase == PH_MOVE_Y) begin
			if (step_cnt == 16'd0) begin
				phase = PH_IDLE;
				cur_col = dest_col;
				cur_row = dest_row;
				return ST_OK;
			end
			r.y_step = 1'b1;
			r.step_forward = fwd[1];
			step_cnt = step_cnt - 16'd1;
			tick_timer = reload(move_per);
		end
		return ST_NONE;
	endfunction

	function automatic res_t step_gantry(cmd_t c);
		res_t        r;
		logic [2:0]  st;
		int          col_lim, row_lim;
		logic [15:0] dx, dy;
		r = '0;
		st = ST_NONE;
		if (phase != PH_IDLE) begin
			st = advance_axes(c, r);
			if (st == ST_NONE && (c.operation == OP_HOME || c.operation == OP_GOTO))
				st = ST_BUSY;
		end else if (c.operation == OP_HOME) begin
			phase = PH_HOME_X;
			step_cnt = 16'd0;
			tick_timer = 16'd0;
		end else if (c.operation == OP_GOTO) begin
			col_lim = (int'(cols) < MAX_COLUMNS) ? int'(cols) : MAX_COLUMNS;
			row_lim = (int'(rows) < MAX_ROWS) ? int'(rows) : MAX_ROWS;
			if (int'(c.target_col) >= col_lim || int'(c.target_row) >= row_lim) begin
				st = ST_OOB;
			end else begin
				fwd = 2'b00;
				if (c.target_col >= cur_col) begin
					dx = {12'd0, c.target_col - cur_col};
					fwd[0] = 1'b1;
				end else begin
					dx = {12'd0, cur_col - c.target_col};
				end
				if (c.target_row >= cur_row) begin
					dy = {12'd0, c.target_row - cur_row};
					fwd[1] = 1'b1;
				end else begin
					dy = {12'd0, cur_row - c.target_row};
				end
				step_cnt = dx * {4'd0, x_spc};
				y_backlog = dy * {4'd0, y_spc};
				dest_col = c.target_col;
				dest_row = c.target_row;
				tick_timer = 16'd0;
				phase = PH_MOVE_X;
			end
		end
		r.busy_res = (phase != PH_IDLE);
		r.status = st;
		r.position_col = cur_col;
		r.position_row = cur_row;
		r.is_homed = homed;
		return r;
	endfunction

	task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			move_per = RST_MOVE_PERIOD;
			home_per = RST_HOME_PERIOD;
			x_spc = RST_X_SPC;
			y_spc = RST_Y_SPC;
			cols = RST_GRID_COLS;
			rows = RST_GRID_ROWS;
			x_lim = RST_X_LIMIT;
			y_lim = RST_Y_LIMIT;
			phase = PH_IDLE;
			step_cnt = 16'd0;
			tick_timer = 16'd0;
			y_backlog = 16'd0;
			fwd = 2'b00;
			cur_col = 4'd0;
			cur_row = 4'd0;
			dest_col = 4'd0;
			dest_row = 4'd0;
			homed = 1'b0;
			due_outputs.delete();
			waiting <= 0;
			seq_busy <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.payload.reg_index)
					REG_MOVE_PERIOD: move_per = cfg.payload.wdata;
					REG_HOME_PERIOD: home_per = cfg.payload.wdata;
					REG_X_SPC:       x_spc = cfg.payload.wdata[11:0];
					REG_Y_SPC:       y_spc = cfg.payload.wdata[11:0];
					REG_GRID_COLS:   cols = cfg.payload.wdata[4:0];
					REG_GRID_ROWS:   rows = cfg.payload.wdata[4:0];
					REG_X_LIMIT:     x_lim = cfg.payload.wdata;
					REG_Y_LIMIT:     y_lim = cfg.payload.wdata;
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (due_outputs.size() == 0) begin
					err_count++;
					$display("%0t: result %p with nothing expected", $time, res.payload);
				end else begin
					want = due_outputs.pop_front();
					check_field("x_step", 4'(want.x_step), 4'(res.payload.x_step));
					check_field("y_step", 4'(want.y_step), 4'(res.payload.y_step));
					check_field("step_forward", 4'(want.step_forward),
						4'(res.payload.step_forward));
					check_field("busy_res", 4'(want.busy_res), 4'(res.payload.busy_res));
					check_field("status", 4'(want.status), 4'(res.payload.status));
					check_field("position_col", want.position_col, res.payload.position_col);
					check_field("position_row", want.position_row, res.payload.position_row);
					check_field("is_homed", 4'(want.is_homed), 4'(res.payload.is_homed));
				end
			end
			if (cmd.valid && cmd.ready)
				due_outputs.push_back(step_gantry(cmd.payload));
			waiting <= due_outputs.size();
			seq_busy <= (phase != PH_IDLE);
		end
	end

endmodule

/* tb/tb.sv */
// Stimulus and verdict for the grid cell stepper positioner.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gcsp_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_SPARE    = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   fails, waiting;
	logic seq_busy;
	bit   calm = 1'b0;

	gcsp_cmd_if cmd_ch ();
	gcsp_res_if res_ch ();
	gcsp_cfg_if cfg_ch ();

	grid_cell_stepper_positioner_unit #(
		.MAX_COLUMNS(16),
		.MAX_ROWS(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	gcsp_result_check #(
		.MAX_COLUMNS(16),
		.MAX_ROWS(16)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch),
		.fails(fails),
		.waiting(waiting),
		.seq_busy(seq_busy)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	task automatic send(cmd_t c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
	endtask

	task automatic issue(logic [1:0] op, logic [3:0] col, logic [3:0] row, logic xl, logic yl);
		cmd_t c;
		c.operation = op;
		c.target_col = col;
		c.target_row = row;
		c.x_home_level = xl;
		c.y_home_level = yl;
		send(c);
	endtask

	// hold until every transfer so far has its result checked
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// advance with triggered endstops until no sequence runs
	task automatic park();
		settle();
		while (seq_busy) begin
			issue(OP_TICK, 4'd0, 4'd0, 1'b0, 1'b0);
			settle();
		end
	endtask

	task automatic put_reg(logic [2:0] idx, logic [15:0] d);
		cfg_t w;
		w.reg_index = idx;
		w.wdata = d;
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [15:0] grid_size();
		logic [15:0] d;
		int          pick;
		d = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			d[4:0] = 5'd0;
		else if (pick == 1)
			d[4:0] = 5'($urandom_range(17, 31));
		else
			d[4:0] = 5'($urandom_range(1, 16));
		return d;
	endfunction

	task automatic random_setup();
		logic [15:0] d;
		put_reg(REG_MOVE_PERIOD, 16'($urandom_range(0, 3)));
		put_reg(REG_HOME_PERIOD, 16'($urandom_range(0, 3)));
		d = 16'($urandom);
		d[11:0] = 12'($urandom_range(0, 3));
		put_reg(REG_X_SPC, d);
		d = 16'($urandom);
		d[11:0] = 12'($urandom_range(0, 3));
		put_reg(REG_Y_SPC, d);
		put_reg(REG_GRID_COLS, grid_size());
		put_reg(REG_GRID_ROWS, grid_size());
		put_reg(REG_X_LIMIT, 16'($urandom_range(0, 30)));
		put_reg(REG_Y_LIMIT, 16'($urandom_range(0, 30)));
	endtask

	function automatic cmd_t draw_item();
		cmd_t c;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			c.operation = OP_TICK;
		else if (pick < 68)
			c.operation = OP_HOME;
		else if (pick < 94)
			c.operation = OP_GOTO;
		else
			c.operation = OP_SPARE;
		c.target_col = 4'($urandom_range(0, 15));
		c.target_row = 4'($urandom_range(0, 15));
		c.x_home_level = ($urandom_range(0, 7) != 0);
		c.y_home_level = ($urandom_range(0, 7) != 0);
		return c;
	endfunction

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: a move to the last cell of the default grid, commands refused while it steps
		issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_GOTO, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_GOTO, 4'd3, 4'd2, 1'b1, 1'b1);
		issue(OP_GOTO, 4'd2, 4'd3, 1'b1, 1'b1);
		issue(OP_GOTO, 4'd15, 4'd15, 1'b1, 1'b1);
		issue(OP_SPARE, 4'd15, 4'd15, 1'b0, 1'b0);
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b0, 1'b0);
		settle();

		put_reg(REG_MOVE_PERIOD, 16'd1);
		put_reg(REG_HOME_PERIOD, 16'd2);
		put_reg(REG_X_SPC, 16'd1);
		put_reg(REG_Y_SPC, 16'd2);
		put_reg(REG_GRID_COLS, 16'd16);
		put_reg(REG_GRID_ROWS, 16'd16);
		put_reg(REG_X_LIMIT, 16'd3);
		put_reg(REG_Y_LIMIT, 16'd2);

		// X endstop never seen, with a rejected command on the way
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		repeat (5) issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		// move forward then back, unhomed
		issue(OP_GOTO, 4'd1, 4'd2, 1'b1, 1'b1);
		issue(OP_GOTO, 4'd5, 4'd5, 1'b1, 1'b1);
		repeat (5) issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_GOTO, 4'd0, 4'd0, 1'b1, 1'b1);
		repeat (6) issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		// homing that finishes on a tick carrying a command
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b0, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b0, 1'b1);
		issue(OP_GOTO, 4'd1, 4'd1, 1'b0, 1'b0);
		// Y endstop never seen
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		repeat (6) issue(OP_TICK, 4'd0, 4'd0, 1'b0, 1'b1);
		park();

		put_reg(REG_MOVE_PERIOD, 16'hFFFF);
		put_reg(REG_HOME_PERIOD, 16'hFFFF);
		put_reg(REG_X_SPC, 16'h0FFF);
		put_reg(REG_Y_SPC, 16'h0FFF);
		put_reg(REG_GRID_COLS, 16'd0);
		put_reg(REG_GRID_ROWS, 16'd31);
		put_reg(REG_X_LIMIT, 16'hFFFF);
		put_reg(REG_Y_LIMIT, 16'hFFFF);
		issue(OP_GOTO, 4'd0, 4'd0, 1'b0, 1'b0);
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b0, 1'b0);
		settle();
		put_reg(REG_GRID_COLS, 16'd31);
		put_reg(REG_GRID_ROWS, 16'd0);
		issue(OP_GOTO, 4'd0, 4'd0, 1'b1, 1'b1);
		settle();
		put_reg(REG_GRID_ROWS, 16'd16);
		put_reg(REG_X_LIMIT, 16'd0);
		issue(OP_GOTO, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_HOME, 4'd0, 4'd0, 1'b1, 1'b1);
		issue(OP_TICK, 4'd0, 4'd0, 1'b1, 1'b1);
		park();

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			random_setup();
			calm = (ph % 3 == 1);
			repeat (205) send(draw_item());
		end
		calm = 1'b0;
		settle();
		repeat (10) @(posedge clk);

		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
